FILE: hdl/ple_pkg.sv
package ple_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int LABEL_BITS_DEF = 8;

  localparam int LABEL_W     = 8;
  localparam int WEIGHT_W    = 16;
  localparam int HEIGHT_W    = 16;
  localparam int WIDTH_CFG_W = 11;
  localparam int ENERGY_W    = 54;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;

  // weight times 2..4 needs two extra bits, the sum of two terms one more
  localparam int TERM_W = WEIGHT_W + 2;
  localparam int SUM_W  = TERM_W + 1;

  typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;
  typedef logic signed [WEIGHT_W-1:0]  weight_t;
  typedef logic signed [TERM_W-1:0]    term_t;
  typedef logic signed [SUM_W-1:0]     term_sum_t;
  typedef logic signed [ENERGY_W-1:0]  energy_t;

  localparam cfg_idx_t CFG_ALPHA  = 8'd0;
  localparam cfg_idx_t CFG_BETA   = 8'd1;
  localparam cfg_idx_t CFG_HEIGHT = 8'd2;
  localparam cfg_idx_t CFG_WIDTH  = 8'd3;

  localparam logic [WEIGHT_W-1:0]    ALPHA_RST  = 16'd256;
  localparam logic [WEIGHT_W-1:0]    BETA_RST   = 16'd0;
  localparam logic [HEIGHT_W-1:0]    HEIGHT_RST = 16'd2;
  localparam logic [WIDTH_CFG_W-1:0] WIDTH_RST  = 11'd2;

  // weight * (2 + near + far), zero when the pair does not exist
  function automatic term_t pair_term(weight_t w, logic en, logic near_edge, logic far_edge);
    term_t wx;
    term_t res;
    wx = TERM_W'(w);
    if (!en) begin
      res = '0;
    end else if (near_edge && far_edge) begin
      res = wx <<< 2;
    end else if (near_edge || far_edge) begin
      res = (wx <<< 1) + wx;
    end else begin
      res = wx <<< 1;
    end
    return res;
  endfunction

endpackage

FILE: hdl/ple_ram.sv
module ple_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read and a write of the same entry return the old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/potts_label_energy.sv
// Frame total: the last pixel of a frame passes the stage 1, stage 2 and output registers
//   onto out_tdata; other pixels give no result.
// Throughput: one pixel per cycle, set by one line-buffer read and write per pixel.
//   The last pixel of a frame waits while the previous total is still in flight or unread.
// Reset (rst_n, synchronous): registers to their defaults, positions and accumulator clear.
//   The line buffer is not cleared; row 0 writes every entry before it is read.
module potts_label_energy
  import ple_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int LABEL_BITS = LABEL_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // cfg port
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] pixel_label
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [53:0] energy_total, [55:54] zero
);

  localparam int LB = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;
  localparam int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CB = $clog2(MAX_WIDTH + 1);
  localparam int WW = (CB > WIDTH_CFG_W) ? CB : WIDTH_CFG_W;

  // configuration
  logic [WEIGHT_W-1:0]    alpha_r, beta_r;
  logic [HEIGHT_W-1:0]    height_r;
  logic [WIDTH_CFG_W-1:0] width_r;

  // positions
  logic [IW-1:0]       col_r, col_nxt;
  logic [HEIGHT_W-1:0] row_r, row_nxt;
  logic [LB-1:0]       left_r, left_nxt;

  // stage 1: line buffer data arrives
  logic          s1_valid_r;
  logic          s1_last_r;
  logic [LB-1:0] s1_lab_r, s1_left_r;
  logic          s1_col_en_r, s1_col_near_r, s1_col_far_r;
  logic          s1_row_en_r, s1_row_near_r, s1_row_far_r;
  logic [LB-1:0] up_lab;

  // stage 2: accumulate
  logic      s2_valid_r, s2_last_r;
  term_sum_t s2_sum_r;
  energy_t   acc_r, acc_nxt;
  energy_t   acc_sum;

  // output register
  logic    out_valid_r, out_valid_nxt;
  energy_t out_energy_r, out_energy_nxt;

  logic [WW-1:0]       w_cfg, w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic                last_col, last_row, frame_last, result_busy, accept;
  logic [LB-1:0]       lab;
  weight_t             left_w, up_w;
  term_sum_t           s1_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= ALPHA_RST;
      beta_r   <= BETA_RST;
      height_r <= HEIGHT_RST;
      width_r  <= WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ALPHA:  alpha_r  <= cfg_data;
        CFG_BETA:   beta_r   <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        CFG_WIDTH:  width_r  <= cfg_data[WIDTH_CFG_W-1:0];
        default:    ;
      endcase
    end
  end

  // clamp geometry
  always_comb begin
    w_cfg = WW'(width_r);
    if (w_cfg > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else if (w_cfg < WW'(2)) begin
      w_eff = WW'(2);
    end else begin
      w_eff = w_cfg;
    end
    h_eff = (height_r < HEIGHT_W'(2)) ? HEIGHT_W'(2) : height_r;
  end

  assign last_col    = WW'(col_r) >= (w_eff - WW'(1));
  assign last_row    = row_r >= (h_eff - HEIGHT_W'(1));
  assign frame_last  = last_col && last_row;
  assign result_busy = out_valid_r || (s1_valid_r && s1_last_r) || (s2_valid_r && s2_last_r);
  assign in_tready   = !(frame_last && result_busy);
  assign accept      = in_tvalid && in_tready;
  assign lab         = in_tdata[LB-1:0];

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    left_nxt = left_r;
    if (accept) begin
      left_nxt = lab;
      if (!last_col) begin
        col_nxt = col_r + IW'(1);
      end else begin
        col_nxt = '0;
        if (!last_row) begin
          row_nxt = row_r + HEIGHT_W'(1);
        end else begin
          row_nxt  = '0;
          left_nxt = '0;
        end
      end
    end
  end

  ple_ram #(
    .WIDTH (LB),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (accept),
    .waddr (col_r),
    .wdata (lab),
    .re    (accept),
    .raddr (col_r),
    .rdata (up_lab)
  );

  always_comb begin
    left_w = (s1_lab_r == s1_left_r) ? weight_t'(alpha_r) : weight_t'(beta_r);
    up_w   = (s1_lab_r == up_lab)    ? weight_t'(alpha_r) : weight_t'(beta_r);
    s1_sum = SUM_W'(pair_term(left_w, s1_col_en_r, s1_col_near_r, s1_col_far_r))
           + SUM_W'(pair_term(up_w, s1_row_en_r, s1_row_near_r, s1_row_far_r));
  end

  assign acc_sum = acc_r + ENERGY_W'(s2_sum_r);

  always_comb begin
    acc_nxt        = acc_r;
    out_energy_nxt = out_energy_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    if (s2_valid_r) begin
      if (s2_last_r) begin
        acc_nxt        = '0;
        out_energy_nxt = acc_sum;
        out_valid_nxt  = 1'b1;
      end else begin
        acc_nxt = acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      left_r      <= left_nxt;
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    s1_last_r     <= frame_last;
    s1_lab_r      <= lab;
    s1_left_r     <= left_r;
    s1_col_en_r   <= col_r != '0;
    s1_col_near_r <= col_r == IW'(1);
    s1_col_far_r  <= last_col;
    s1_row_en_r   <= row_r != '0;
    s1_row_near_r <= row_r == HEIGHT_W'(1);
    s1_row_far_r  <= last_row;
    s2_last_r     <= s1_last_r;
    s2_sum_r      <= s1_sum;
    out_energy_r  <= out_energy_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - ENERGY_W){1'b0}}, out_energy_r};

`ifndef SYNTHESIS
  a_stall_only_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && !in_tready) |-> frame_last)
    else $error("input stalled on a pixel that is not the frame end");

  a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_last_r) |-> !out_valid_r)
    else $error("frame total arrives while the output register is full");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frame_last) |=> (col_r == '0 && row_r == '0))
    else $error("positions not cleared at frame end");

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_last_r) |=> (acc_r == '0))
    else $error("accumulator not cleared after frame total");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < WW'(MAX_WIDTH))
    else $error("column position beyond line buffer");
`endif

endmodule

FILE: tb/sv/potts_label_energy_tb.sv
module potts_label_energy_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PIXELS  = 400;
  localparam int REPORT_MAX     = 10;
  localparam int PLAN_LEN       = 31;

  localparam cfg_idx_t CFG_FIRST_SPARE = cfg_idx_t'(CFG_WIDTH + 8'd1);
  localparam cfg_idx_t CFG_IDX_TOP     = '1;

  typedef enum logic [1:0] {STEP_CFG, STEP_PIX, STEP_PIX_LAST} step_kind_e;

  typedef struct packed {
    step_kind_e              kind;
    cfg_idx_t                idx;
    logic [CFG_DATA_W-1:0]   data;
    logic [LABEL_W-1:0]      lab;
    energy_t                 total;   // typed-in frame total, STEP_PIX_LAST only
  } plan_step_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  cfg_idx_t               cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [7:0] pixel_label
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [53:0] energy_total, [55:54] zero

  // mirror of the block's registers and frame state
  weight_t                alpha_w;
  weight_t                beta_w;
  logic [HEIGHT_W-1:0]    height_r;
  logic [WIDTH_CFG_W-1:0] width_r;
  logic [LABEL_W-1:0]     line_mem [MAX_WIDTH_DEF];
  logic [LABEL_W-1:0]     left_lab;
  int unsigned            row_pos;
  int unsigned            col_pos;
  energy_t                energy_acc;

  energy_t                totals_due [$];
  energy_t                want_total;
  plan_step_t             plan [PLAN_LEN];

  int  pixels_sent;
  int  frames_done;
  int  cfg_writes;
  int  totals_checked;
  int  fault_count;
  bit  sender_eager;
  bit  sink_eager;
  bit  hold_req;

  potts_label_energy uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic model_reset();
    alpha_w    = weight_t'(ALPHA_RST);
    beta_w     = weight_t'(BETA_RST);
    height_r   = HEIGHT_RST;
    width_r    = WIDTH_RST;
    left_lab   = '0;
    row_pos    = 0;
    col_pos    = 0;
    energy_acc = '0;
    foreach (line_mem[i]) line_mem[i] = '0;
  endtask

  function automatic energy_t pair_cost(bit same, int unsigned mult);
    longint w;
    w = same ? longint'(alpha_w) : longint'(beta_w);
    return energy_t'(w * longint'(mult));
  endfunction

  // one pixel into the mirrored frame state; frame_end flags the total
  task automatic potts_step(input logic [LABEL_W-1:0] lab, output bit frame_end,
                            output energy_t total);
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned idx;
    bit          last_c;
    bit          last_r;
    w_eff = width_r;
    h_eff = height_r;
    if (w_eff < 2) w_eff = 2;
    if (w_eff > MAX_WIDTH_DEF) w_eff = MAX_WIDTH_DEF;
    if (h_eff < 2) h_eff = 2;
    last_c    = col_pos >= w_eff - 1;
    last_r    = row_pos >= h_eff - 1;
    idx       = col_pos % MAX_WIDTH_DEF;
    frame_end = 1'b0;
    total     = '0;
    // interior pairs count twice, mirror terms add one at each border
    if (col_pos > 0)
      energy_acc += pair_cost(lab == left_lab, 2 + (col_pos == 1) + last_c);
    if (row_pos > 0)
      energy_acc += pair_cost(lab == line_mem[idx], 2 + (row_pos == 1) + last_r);
    line_mem[idx] = lab;
    left_lab      = lab;
    if (!last_c) begin
      col_pos++;
    end else begin
      col_pos = 0;
      if (!last_r) begin
        row_pos++;
      end else begin
        frame_end  = 1'b1;
        total      = energy_acc;
        energy_acc = '0;
        row_pos    = 0;
        left_lab   = '0;
        frames_done++;
      end
    end
  endtask

  function automatic logic [LABEL_W-1:0] pick_label();
    case ($urandom_range(0, 3))
      0:       return LABEL_W'($urandom_range(0, 255));
      1:       return ($urandom_range(0, 1) != 0) ? {LABEL_W{1'b1}} : {LABEL_W{1'b0}};
      default: return LABEL_W'($urandom_range(0, 2));
    endcase
  endfunction

  // mostly small frames; out-of-range geometry now and then
  function automatic logic [CFG_DATA_W-1:0] reg_value(cfg_idx_t idx);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    case (idx)
      CFG_HEIGHT: begin
        if (roll == 0) return CFG_DATA_W'($urandom_range(0, 1));
        if (roll == 1) return CFG_DATA_W'($urandom_range(7, 12));
        return CFG_DATA_W'($urandom_range(2, 6));
      end
      CFG_WIDTH: begin
        if (roll == 0) return CFG_DATA_W'($urandom_range(0, 1));
        if (roll == 1) return CFG_DATA_W'($urandom_range(9, 40));
        return CFG_DATA_W'($urandom_range(2, 8));
      end
      default: begin
        if (roll == 0) return 16'h8000;
        if (roll == 1) return 16'h7FFF;
        if (roll == 2) return '0;
        return CFG_DATA_W'($urandom_range(0, 65535));
      end
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge with cfg_valid low
  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ALPHA:  alpha_w  = weight_t'(val);
      CFG_BETA:   beta_w   = weight_t'(val);
      CFG_HEIGHT: height_r = val;
      CFG_WIDTH:  width_r  = val[WIDTH_CFG_W-1:0];
      default:    ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop offering pixels until every total is back and the pipe is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (totals_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_pixel(input logic [LABEL_W-1:0] lab, input bit typed,
                            input energy_t typed_total, output bit frame_end);
    int      gap;
    energy_t total;
    gap = sender_eager ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= lab;
    do @(posedge clk); while (!in_tready);
    potts_step(lab, frame_end, total);
    if (frame_end) totals_due.push_back(typed ? typed_total : total);
    pixels_sent++;
    @(negedge clk);
  endtask

  // mid_at >= 0 changes height or width once the frame holds that many pixels
  task automatic send_frame(input int mid_at);
    bit done;
    int n;
    done = 1'b0;
    n    = 0;
    while (!done) begin
      if (n == mid_at) begin
        settle();
        if ($urandom_range(0, 1) != 0) cfg_write(CFG_HEIGHT, reg_value(CFG_HEIGHT));
        else cfg_write(CFG_WIDTH, reg_value(CFG_WIDTH));
      end
      send_pixel(pick_label(), 1'b0, '0, done);
      n++;
    end
  endtask

  task automatic report_fault(input string what, input energy_t want, input energy_t got);
    fault_count++;
    if (fault_count <= REPORT_MAX)
      $display("%0t mismatch, %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      totals_checked++;
      if (totals_due.size() == 0) begin
        report_fault("total with no frame pending", '0, energy_t'(out_tdata[ENERGY_W-1:0]));
      end else begin
        want_total = totals_due.pop_front();
        if (out_tdata[ENERGY_W-1:0] !== want_total)
          report_fault("energy_total", want_total, energy_t'(out_tdata[ENERGY_W-1:0]));
      end
    end
  end

  initial begin : result_sink
    int stall;
    int taken;
    out_tready = 1'b0;
    taken      = 0;
    sink_eager = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = sink_eager ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
      if (taken % 20 == 0) sink_eager = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    bit done;
    int start_px;
    int first;
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    sender_eager   = 1'b0;
    hold_req       = 1'b0;
    pixels_sent    = 0;
    frames_done    = 0;
    cfg_writes     = 0;
    totals_checked = 0;
    fault_count    = 0;
    model_reset();

    plan = '{
      // reset weights, 2x2 all equal: 16 * 256
      '{STEP_PIX,      CFG_ALPHA,   16'h0000, 8'h00, energy_t'(0)},
      '{STEP_PIX,      CFG_ALPHA,   16'h0000, 8'h00, energy_t'(0)},
      '{STEP_PIX,      CFG_ALPHA,   16'h0000, 8'h00, energy_t'(0)},
      '{STEP_PIX_LAST, CFG_ALPHA,   16'h0000, 8'h00, energy_t'(4096)},
      '{STEP_CFG,      CFG_ALPHA,   16'h8000, 8'h00, energy_t'(0)},
      '{STEP_CFG,      CFG_BETA,    16'h7FFF, 8'h00, energy_t'(0)},
      // all equal at most negative alpha
      '{STEP_PIX,      CFG_ALPHA,   16'h0000, 8'hFF, energy_t'(0)},
      '{STEP_PIX,      CFG_ALPHA,   16'h0000, 8'hFF, energy_t'(0)},
      '{STEP_PIX,      CFG_ALPHA,   16'h0000, 8'hFF, energy_t'(0)},
      '{STEP_PIX_LAST, CFG_ALPHA,   16'h0000, 8'hFF, energy_t'(-524288)},
      // checkerboard, every pair differs at most positive beta
      '{STEP_PIX,      CFG_ALPHA,   16'h0000, 8'h55, energy_t'(0)},
      '{STEP_PIX,      CFG_ALPHA,   16'h0000, 8'hAA, energy_t'(0)},
      '{STEP_PIX,      CFG_ALPHA,   16'h0000, 8'hAA, energy_t'(0)},
      '{STEP_PIX_LAST, CFG_ALPHA,   16'h0000, 8'h55, energy_t'(524272)},
      // geometry below range clamps to 2x2, unknown index is dropped
      '{STEP_CFG,      CFG_HEIGHT,  16'h0000, 8'h00, energy_t'(0)},
      '{STEP_CFG,      CFG_WIDTH,   16'h0001, 8'h00, energy_t'(0)},
      '{STEP_CFG,      CFG_IDX_TOP, 16'hFFFF, 8'h00, energy_t'(0)},
      '{STEP_PIX,      CFG_ALPHA,   16'h0000, 8'h01, energy_t'(0)},
      '{STEP_PIX,      CFG_ALPHA,   16'h0000, 8'h80, energy_t'(0)},
      '{STEP_PIX,      CFG_ALPHA,   16'h0000, 8'h80, energy_t'(0)},
      '{STEP_PIX,      CFG_ALPHA,   16'h0000, 8'h7F, energy_t'(0)},
      // 3 wide, tallest height, then shrunk mid-frame to end it early
      '{STEP_CFG,      CFG_WIDTH,   16'h0003, 8'h00, energy_t'(0)},
      '{STEP_CFG,      CFG_HEIGHT,  16'hFFFF, 8'h00, energy_t'(0)},
      '{STEP_PIX,      CFG_ALPHA,   16'h0000, 8'h10, energy_t'(0)},
      '{STEP_PIX,      CFG_ALPHA,   16'h0000, 8'h10, energy_t'(0)},
      '{STEP_PIX,      CFG_ALPHA,   16'h0000, 8'h20, energy_t'(0)},
      '{STEP_PIX,      CFG_ALPHA,   16'h0000, 8'h10, energy_t'(0)},
      '{STEP_PIX,      CFG_ALPHA,   16'h0000, 8'h33, energy_t'(0)},
      '{STEP_CFG,      CFG_HEIGHT,  16'h0001, 8'h00, energy_t'(0)},
      '{STEP_CFG,      CFG_WIDTH,   16'h0002, 8'h00, energy_t'(0)},
      '{STEP_PIX,      CFG_ALPHA,   16'h0000, 8'h20, energy_t'(0)}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        if (i == 0 || plan[i-1].kind != STEP_CFG) settle();
        cfg_write(plan[i].idx, plan[i].data);
      end else begin
        send_pixel(plan[i].lab, plan[i].kind == STEP_PIX_LAST, plan[i].total, done);
      end
    end

    // back-pressure: result side holds off while pixels keep coming
    settle();
    cfg_write(CFG_WIDTH, 16'd2);
    cfg_write(CFG_HEIGHT, 16'd2);
    cfg_write(CFG_ALPHA, reg_value(CFG_ALPHA));
    cfg_write(CFG_BETA, reg_value(CFG_BETA));
    hold_req     = 1'b1;
    sender_eager = 1'b1;
    repeat (64) send_pixel(pick_label(), 1'b0, '0, done);
    sender_eager = 1'b0;

    // full line buffer: oversized width clamps to the buffer depth, then the
    // frame is cut short by narrowing it early in the second row
    settle();
    cfg_write(CFG_WIDTH, '1);
    cfg_write(CFG_HEIGHT, 16'd2);
    repeat (MAX_WIDTH_DEF + 8) send_pixel(pick_label(), 1'b0, '0, done);
    settle();
    cfg_write(CFG_WIDTH, 16'd8);
    send_frame(-1);

    // every line buffer entry is written now, so any mid-frame change is safe
    start_px = pixels_sent;
    while (pixels_sent - start_px < RANDOM_PIXELS) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        first = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(0, 1) != 0)
            cfg_write(cfg_idx_t'((first + k) % 4), reg_value(cfg_idx_t'((first + k) % 4)));
        end
        if ($urandom_range(0, 5) == 0)
          cfg_write(cfg_idx_t'($urandom_range(CFG_FIRST_SPARE, CFG_IDX_TOP)),
                    CFG_DATA_W'($urandom_range(0, 65535)));
      end
      sender_eager = ($urandom_range(0, 3) == 0);
      send_frame(($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 20)) : -1);
    end
    sender_eager = 1'b0;

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (totals_due.size() != 0) report_fault("frame total never came", totals_due[0], '0);

    $display("run: %0d pixels in %0d frames, %0d register writes, %0d totals checked",
             pixels_sent, frames_done, cfg_writes, totals_checked);
    $display("run: 2x2 up to 1024-column frames, clamped geometry, mid-frame resizes, %0d-cycle stall",
             HOLD_CYCLES);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
